[sv/assert_macros.svh]
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cip_pkg.sv]
package cip_pkg;

  localparam int unsigned RateW    = 32;
  localparam int unsigned AreaW    = 16;
  localparam int unsigned DewW     = 16;
  localparam int unsigned StepW    = 17;
  localparam int unsigned FracW    = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 17;

  localparam logic [DewW-1:0]  MaxDewReset = 16'd6554;
  localparam logic [StepW-1:0] StepReset   = 17'd1800;
  // ln 2 in Q0.32
  localparam logic [31:0]      Ln2Q32      = 32'd2977044472;
  // 2^31 / ln 2, held a little low so the quotient estimate never runs high
  localparam logic [31:0]      Ln2RecipQ63 = 32'd3098164000;
  // 1.0 in Q1.15
  localparam logic [FracW-1:0] FracOne     = 16'd32768;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_DEW      = 1'b0,
    CFG_STEP_SECONDS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    LAND_SOIL  = 2'd0,
    LAND_ICE   = 2'd1,
    LAND_OTHER = 2'd2,
    LAND_LAKE  = 2'd3
  } land_class_e;

  typedef struct packed {
    logic [RateW-1:0] rain_rate;
    logic [RateW-1:0] snow_rate;
    logic [AreaW-1:0] leaf_area;
    logic [AreaW-1:0] stem_area;
    logic             veg_exposed;
    logic [1:0]       land_class;
    logic             wall_column;
    logic             cap_snow;
    logic [RateW-1:0] irrigation_rate;
  } cip_in_t;

  typedef struct packed {
    logic [RateW-1:0] canopy_water_out;
    logic [RateW-1:0] drip_rate;
    logic [RateW-1:0] snow_throughfall;
    logic [RateW-1:0] rain_throughfall;
    logic [RateW-1:0] ground_total;
    logic [RateW-1:0] capped_liquid;
    logic [RateW-1:0] capped_ice;
    logic [RateW-1:0] snow_on_ground;
    logic [RateW-1:0] rain_on_ground;
    logic [FracW-1:0] wet_fraction;
    logic [FracW-1:0] dry_fraction;
  } cip_out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CAP, ST_CAPW, ST_XMUL, ST_XCOR, ST_TMUL, ST_TREC, ST_TCOR, ST_EXPF,
    ST_FLUX, ST_SNOW, ST_RAIN, ST_HMUL, ST_HCHK, ST_DDIV, ST_DMUL, ST_DMW,
    ST_SDIV, ST_GROUND, ST_YDIV, ST_YSQ, ST_CBINIT, ST_CBSQ, ST_CBCU,
    ST_CBCMP, ST_CBFIN, ST_FDRY, ST_FDW, ST_FDIV, ST_OUT
  } cip_state_e;

  // floor(2^32 / k) for the series terms, k from 2 to 16
  function automatic logic [31:0] taylor_recip(input logic [4:0] k);
    logic [31:0] r;
    case (k)
      5'd2:    r = 32'd2147483648;
      5'd3:    r = 32'd1431655765;
      5'd4:    r = 32'd1073741824;
      5'd5:    r = 32'd858993459;
      5'd6:    r = 32'd715827882;
      5'd7:    r = 32'd613566756;
      5'd8:    r = 32'd536870912;
      5'd9:    r = 32'd477218588;
      5'd10:   r = 32'd429496729;
      5'd11:   r = 32'd390451572;
      5'd12:   r = 32'd357913941;
      5'd13:   r = 32'd330382099;
      5'd14:   r = 32'd306783378;
      5'd15:   r = 32'd286331153;
      5'd16:   r = 32'd268435456;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/canopy_interception_step.sv]
// Canopy interception for one vegetated column per item, keeping the canopy water store
// between items. One item is worked at a time: in_ready_o is high only while idle, and the
// result stays on out_item_o until taken. Lake items finish soonest; the time an item
// takes is set by a shared one-bit-per-cycle divider (up to four divisions an item: the
// drip rate, its snow share, the store-to-capacity ratio and the dry fraction), by 15
// series terms on the shared 40x32 multiplier, and by a 20-bit cube root. The exponent
// range reduction is a reciprocal multiply with one correction step.
// Configuration writes are always taken and must only come while the block is idle.
`include "assert_macros.svh"

module canopy_interception_step
  import cip_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cip_in_t             in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cip_out_t            out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cip_state_e state_q, state_d;
  cip_in_t    item_q;

  logic [DewW-1:0]  mdpa_q;
  logic [StepW-1:0] dt_q;
  logic [31:0]      store_q, store_d;

  logic [32:0] den_q, den_d;
  logic [71:0] prod_q, prod_d;
  logic [39:0] mul_a;
  logic [31:0] mul_b;
  logic [6:0]  n_q, n_d;
  logic [31:0] r_q, r_d, term_q, term_d, p_q, p_d;
  logic signed [34:0] sum_q, sum_d;
  logic [4:0]  k_q, k_d;
  logic [30:0] fpi_q, fpi_d, intr_q, intr_d;
  logic [31:0] thr_s_q, thr_s_d, thr_r_q, thr_r_d;
  logic [31:0] drip_q, drip_d, drip_s_q, drip_s_d, drip_r_q, drip_r_d;
  logic [32:0] gs_q, gs_d;
  logic [33:0] gr_q, gr_d;
  logic [29:0] y_q, y_d;
  logic [59:0] v_q, v_d;
  logic [19:0] c_q, c_d, cand_q, cand_d;
  logic [4:0]  bit_q, bit_d;
  logic [FracW-1:0] fwet_q, fwet_d, fdry_q, fdry_d;

  // shared divider
  logic        div_start;
  logic [63:0] div_dividend;
  logic [32:0] div_divisor;
  logic        div_busy_q, div_done_q;
  logic [5:0]  div_cnt_q;
  logic [32:0] div_rem_q, div_dsr_q;
  logic [63:0] div_quo_q;
  logic [33:0] div_shift;
  logic        div_ge;

  // item-derived values
  logic [16:0] vegt;
  logic [32:0] total;
  logic [16:0] dt_eff;
  logic        intercept;

  assign vegt   = {1'b0, item_q.leaf_area} + {1'b0, item_q.stem_area};
  assign total  = {1'b0, item_q.rain_rate} + {1'b0, item_q.snow_rate};
  assign dt_eff = (dt_q == '0) ? 17'd1 : dt_q;
  assign intercept = (item_q.land_class == LAND_SOIL) && !item_q.wall_column &&
                     item_q.veg_exposed && (total != '0);

  // handshakes
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign cfg_ready_o = 1'b1;

  // shared multiplier, registered every cycle
  assign prod_d = 72'(mul_a) * 72'(mul_b);

  // configuration registers and state store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mdpa_q  <= MaxDewReset;
      dt_q    <= StepReset;
      store_q <= '0;
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
      store_q <= store_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MAX_DEW:      mdpa_q <= cfg_data_i[DewW-1:0];
          CFG_STEP_SECONDS: dt_q   <= cfg_data_i;
          default:          ;
        endcase
      end
    end
  end

  // divider control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      div_done_q <= 1'b0;
      if (div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= 6'd63;
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - 6'd1;
        if (div_cnt_q == '0) begin
          div_busy_q <= 1'b0;
          div_done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  assign div_shift = {div_rem_q, div_quo_q[63]};
  assign div_ge    = (div_shift >= {1'b0, div_dsr_q});

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_rem_q <= '0;
      div_quo_q <= div_dividend;
      div_dsr_q <= div_divisor;
    end else if (div_busy_q) begin
      div_rem_q <= div_ge ? 33'(div_shift - {1'b0, div_dsr_q}) : div_shift[32:0];
      div_quo_q <= {div_quo_q[62:0], div_ge};
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
    prod_q   <= prod_d;
    den_q    <= den_d;
    n_q      <= n_d;
    r_q      <= r_d;
    term_q   <= term_d;
    p_q      <= p_d;
    sum_q    <= sum_d;
    k_q      <= k_d;
    fpi_q    <= fpi_d;
    intr_q   <= intr_d;
    thr_s_q  <= thr_s_d;
    thr_r_q  <= thr_r_d;
    drip_q   <= drip_d;
    drip_s_q <= drip_s_d;
    drip_r_q <= drip_r_d;
    gs_q     <= gs_d;
    gr_q     <= gr_d;
    y_q      <= y_d;
    v_q      <= v_d;
    c_q      <= c_d;
    cand_q   <= cand_d;
    bit_q    <= bit_d;
    fwet_q   <= fwet_d;
    fdry_q   <= fdry_d;
  end

  // sequencer
  always_comb begin
    logic [31:0] q_est;
    logic [36:0] qk;
    logic [36:0] remk;
    logic [32:0] sumc;
    logic [32:0] e_val;
    logic [48:0] h_val;
    logic [30:0] cap_val;
    logic [33:0] num_val;
    logic [19:0] cand_v;
    logic [38:0] x_rem;
    logic        x_high;
    logic [31:0] r_v;

    state_d  = state_q;
    store_d  = store_q;
    den_d    = den_q;
    n_d      = n_q;
    r_d      = r_q;
    term_d   = term_q;
    p_d      = p_q;
    sum_d    = sum_q;
    k_d      = k_q;
    fpi_d    = fpi_q;
    intr_d   = intr_q;
    thr_s_d  = thr_s_q;
    thr_r_d  = thr_r_q;
    drip_d   = drip_q;
    drip_s_d = drip_s_q;
    drip_r_d = drip_r_q;
    gs_d     = gs_q;
    gr_d     = gr_q;
    y_d      = y_q;
    v_d      = v_q;
    c_d      = c_q;
    cand_d   = cand_q;
    bit_d    = bit_q;
    fwet_d   = fwet_q;
    fdry_d   = fdry_q;
    mul_a    = '0;
    mul_b    = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    q_est   = prod_q[63:32];
    qk      = 37'(q_est) * 37'(k_q);
    remk    = {5'b0, p_q} - qk;
    sumc    = sum_q[34] ? 33'd0 :
              ((sum_q > 35'sh1_0000_0000) ? 33'h1_0000_0000 : sum_q[32:0]);
    e_val   = (n_q >= 7'd63) ? 33'd0 : (sumc >> n_q[5:0]);
    h_val   = {17'b0, store_q} + prod_q[48:0];
    cap_val = den_q[32:2];
    num_val = {store_q, 2'b00};
    cand_v  = c_q | (20'd1 << bit_q);
    x_rem   = 39'({vegt, 21'b0}) - prod_q[38:0];
    x_high  = (x_rem >= 39'(Ln2Q32));
    r_v     = x_high ? 32'(x_rem - 39'(Ln2Q32)) : x_rem[31:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          thr_s_d  = '0;
          thr_r_d  = '0;
          drip_d   = '0;
          drip_s_d = '0;
          drip_r_d = '0;
          gs_d     = '0;
          gr_d     = '0;
          fwet_d   = '0;
          fdry_d   = '0;
          state_d  = ST_CAP;
        end
      end
      // capacity denominator: max dew times total area
      ST_CAP: begin
        mul_a   = 40'(mdpa_q);
        mul_b   = 32'(vegt);
        state_d = ST_CAPW;
      end
      ST_CAPW: begin
        den_d = prod_q[32:0];
        if (item_q.land_class == LAND_LAKE) begin
          state_d = ST_OUT;
        end else if (item_q.land_class == LAND_ICE) begin
          store_d = '0;
          state_d = ST_GROUND;
        end else if (intercept) begin
          mul_a   = 40'({vegt, 21'b0});
          mul_b   = Ln2RecipQ63;
          state_d = ST_XMUL;
        end else begin
          state_d = ST_GROUND;
        end
      end
      // range reduction x = n*ln2 + r, quotient estimate may be one low
      ST_XMUL: begin
        n_d     = prod_q[69:63];
        mul_a   = 40'(prod_q[69:63]);
        mul_b   = Ln2Q32;
        state_d = ST_XCOR;
      end
      ST_XCOR: begin
        n_d     = n_q + 7'(x_high);
        r_d     = r_v;
        term_d  = r_v;
        sum_d   = 35'sh1_0000_0000 - $signed({3'b000, r_v});
        k_d     = 5'd2;
        state_d = ST_TMUL;
      end
      // series term: term*r, then divide by k through its reciprocal
      ST_TMUL: begin
        mul_a   = 40'(term_q);
        mul_b   = r_q;
        state_d = ST_TREC;
      end
      ST_TREC: begin
        p_d     = prod_q[63:32];
        mul_a   = 40'(prod_q[63:32]);
        mul_b   = taylor_recip(k_q);
        state_d = ST_TCOR;
      end
      ST_TCOR: begin
        if (remk >= 37'(k_q)) begin
          q_est = q_est + 32'd1;
        end
        term_d = q_est;
        if (k_q[0]) begin
          sum_d = sum_q - $signed({3'b000, q_est});
        end else begin
          sum_d = sum_q + $signed({3'b000, q_est});
        end
        k_d = k_q + 5'd1;
        state_d = (k_q == 5'd16) ? ST_EXPF : ST_TMUL;
      end
      // interception fraction
      ST_EXPF: begin
        fpi_d   = 31'((33'h1_0000_0000 - e_val) >> 2);
        state_d = ST_FLUX;
      end
      ST_FLUX: begin
        mul_a   = 40'(total);
        mul_b   = 32'(fpi_q);
        state_d = ST_SNOW;
      end
      ST_SNOW: begin
        intr_d  = prod_q[62:32];
        mul_a   = 40'(item_q.snow_rate);
        mul_b   = 32'(fpi_q);
        state_d = ST_RAIN;
      end
      // throughfall = rate - ceil(rate*fpi)
      ST_RAIN: begin
        thr_s_d = item_q.snow_rate - prod_q[63:32] - 32'(|prod_q[31:0]);
        mul_a   = 40'(item_q.rain_rate);
        mul_b   = 32'(fpi_q);
        state_d = ST_HMUL;
      end
      ST_HMUL: begin
        thr_r_d = item_q.rain_rate - prod_q[63:32] - 32'(|prod_q[31:0]);
        mul_a   = 40'(dt_eff);
        mul_b   = 32'(intr_q);
        state_d = ST_HCHK;
      end
      // store update and overflow check against capacity
      ST_HCHK: begin
        if (h_val > 49'(cap_val)) begin
          store_d      = 32'(cap_val);
          div_start    = 1'b1;
          div_dividend = 64'(h_val - 49'(cap_val));
          div_divisor  = 33'(dt_eff);
          state_d      = ST_DDIV;
        end else begin
          store_d = h_val[31:0];
          state_d = ST_GROUND;
        end
      end
      ST_DDIV: begin
        if (div_done_q) begin
          drip_d  = (|div_quo_q[63:32]) ? 32'hFFFF_FFFF : div_quo_q[31:0];
          state_d = ST_DMUL;
        end
      end
      // snow share of drip
      ST_DMUL: begin
        mul_a   = 40'(drip_q);
        mul_b   = item_q.snow_rate;
        state_d = ST_DMW;
      end
      ST_DMW: begin
        div_start    = 1'b1;
        div_dividend = prod_q[63:0];
        div_divisor  = total;
        state_d      = ST_SDIV;
      end
      ST_SDIV: begin
        if (div_done_q) begin
          drip_s_d = div_quo_q[31:0];
          drip_r_d = drip_q - div_quo_q[31:0];
          state_d  = ST_GROUND;
        end
      end
      // ground fluxes and start of the wet fraction
      ST_GROUND: begin
        if (item_q.wall_column) begin
          gs_d = '0;
          gr_d = '0;
        end else if (!item_q.veg_exposed) begin
          gs_d = 33'(item_q.snow_rate);
          gr_d = 34'(item_q.rain_rate);
        end else begin
          gs_d = 33'(thr_s_q) + 33'(drip_s_q);
          gr_d = 34'(thr_r_q) + 34'(drip_r_q);
        end
        gr_d = gr_d + 34'(item_q.irrigation_rate);
        state_d = ST_FDRY;
        if (item_q.veg_exposed && (store_q != '0)) begin
          if ((den_q == '0) || (num_val >= {1'b0, den_q})) begin
            fwet_d = FracOne;
          end else begin
            div_start    = 1'b1;
            div_dividend = {num_val, 30'b0};
            div_divisor  = den_q;
            state_d      = ST_YDIV;
          end
        end
      end
      ST_YDIV: begin
        if (div_done_q) begin
          y_d     = div_quo_q[29:0];
          state_d = ST_YSQ;
        end
      end
      ST_YSQ: begin
        mul_a   = 40'(y_q);
        mul_b   = 32'(y_q);
        state_d = ST_CBINIT;
      end
      // floor cube root of y^2, one bit per pass
      ST_CBINIT: begin
        v_d     = prod_q[59:0];
        c_d     = '0;
        bit_d   = 5'd19;
        state_d = ST_CBSQ;
      end
      ST_CBSQ: begin
        cand_d  = cand_v;
        mul_a   = 40'(cand_v);
        mul_b   = 32'(cand_v);
        state_d = ST_CBCU;
      end
      ST_CBCU: begin
        mul_a   = prod_q[39:0];
        mul_b   = 32'(cand_q);
        state_d = ST_CBCMP;
      end
      ST_CBCMP: begin
        if (prod_q <= 72'(v_q)) begin
          c_d = cand_q;
        end
        bit_d   = bit_q - 5'd1;
        state_d = (bit_q == '0) ? ST_CBFIN : ST_CBSQ;
      end
      ST_CBFIN: begin
        fwet_d  = 16'(c_q[19:5]);
        state_d = ST_FDRY;
      end
      // dry leaf fraction
      ST_FDRY: begin
        if (item_q.veg_exposed && (vegt != '0)) begin
          mul_a   = 40'(FracOne - fwet_q);
          mul_b   = 32'(item_q.leaf_area);
          state_d = ST_FDW;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_FDW: begin
        div_start    = 1'b1;
        div_dividend = prod_q[63:0];
        div_divisor  = 33'(vegt);
        state_d      = ST_FDIV;
      end
      ST_FDIV: begin
        if (div_done_q) begin
          fdry_d  = div_quo_q[FracW-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result assembly
  logic [34:0] ground_sum;
  logic [31:0] gs_sat, gr_sat;

  assign ground_sum = 35'(gs_q) + 35'(gr_q);
  assign gs_sat     = gs_q[32]      ? 32'hFFFF_FFFF : gs_q[31:0];
  assign gr_sat     = (|gr_q[33:32]) ? 32'hFFFF_FFFF : gr_q[31:0];

  always_comb begin
    out_item_o.canopy_water_out = store_q;
    out_item_o.drip_rate        = drip_q;
    out_item_o.snow_throughfall = thr_s_q;
    out_item_o.rain_throughfall = thr_r_q;
    out_item_o.ground_total     = (|ground_sum[34:32]) ? 32'hFFFF_FFFF : ground_sum[31:0];
    out_item_o.capped_liquid    = item_q.cap_snow ? gr_sat : '0;
    out_item_o.capped_ice       = item_q.cap_snow ? gs_sat : '0;
    out_item_o.snow_on_ground   = item_q.cap_snow ? '0 : gs_sat;
    out_item_o.rain_on_ground   = item_q.cap_snow ? '0 : gr_sat;
    out_item_o.wet_fraction     = fwet_q;
    out_item_o.dry_fraction     = fdry_q;
  end

  `AST_IMPL(a_ready_excl, in_ready_o, !out_valid_o, "input ready while result pending")
  `AST_NEXT(a_out_to_idle, out_valid_o && out_ready_i, in_ready_o, "no return to idle")
  `AST_IMPL(a_div_free, div_start, !div_busy_q, "divider restarted while busy")
  `AST_IMPL(a_frac_sum, out_valid_o,
            17'(out_item_o.wet_fraction) + 17'(out_item_o.dry_fraction) <= 17'(FracOne),
            "wet and dry fractions exceed one")

endmodule
